>>> hdl/srd_pkg.sv
// shared types and constants of the run-length sprite decoder
// no dependencies; imported by srd_result_buf and sprite_rle_decoder_core
package srd_pkg;

  // frame size limits and field widths
  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxHeight  = 1024;
  localparam int unsigned SizeW      = 11;
  localparam int unsigned ColumnW    = 12;
  localparam int unsigned OffsetW    = 20;
  localparam int unsigned RunW       = 7;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned TdataW     = 56;

  // stream codes and limits
  localparam logic [7:0]         RowEndCode  = 8'd128;
  localparam logic [ColumnW-1:0] ColumnLimit = '1;
  localparam logic [OffsetW-1:0] OffsetLimit = '1;
  localparam logic [7:0]         AlphaFull   = 8'hFF;
  localparam logic [7:0]         AlphaHalf   = 8'h80;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_HALF_ALPHA   = 2'd2
  } cfg_idx_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_FRAME_END = 2'd1,
    KIND_DROPPED   = 2'd2
  } kind_e;

  // one result beat
  typedef struct packed {
    kind_e               kind;
    logic [OffsetW-1:0]  offset;
    logic [ValueW-1:0]   value;
  } result_t;

endpackage

>>> hdl/srd_result_buf.sv
// result register with one skid entry for the sprite decoder output stream
// depends on srd_pkg for the result_t beat type
module srd_result_buf import srd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  result_t in_data_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  output result_t out_data_o,
  input  logic    out_ready_i
);

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;

  // input side stalls only once the skid entry is taken
  assign in_ready_o = !skid_valid_q;

  // control: output register refills from skid first, else from input
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      out_valid_q  <= skid_valid_q || in_valid_i;
      skid_valid_q <= 1'b0;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/sprite_rle_decoder_core.sv
// top level of the run-length sprite decoder: code parsing, counters, results
// depends on srd_pkg and srd_result_buf
//
// Usage:
//   s_axis carries the compressed sprite stream, one byte per beat in tdata[7:0].
//   m_axis carries results: tuser is the kind (pixel write, frame end, dropped),
//   tdata holds the pixel offset and the ARGB pixel value.
//   Skip codes, run headers and row ends that do not finish a frame give no
//   result beat; literal bytes give one each, the last row end gives a frame end.
//   Configuration (width, height, half alpha) goes through cfg_we_i/cfg_idx_i/
//   cfg_wdata_i while the stream is idle; the next beat sees the new values.
// Timing:
//   one byte is accepted every cycle while s_axis_tready_o is high. The rate is
//   set by the single decode stage, whose counters are updated at the accepting
//   edge, feeding the output register that drives m_axis. When the receiver
//   stalls, one more result goes into the skid entry and the input then stalls
//   until the output register drains.
// Reset:
//   the decoder expects a code byte at column 0 of row 0, the output is empty,
//   width and height are 1 and full alpha is selected.
module sprite_rle_decoder_core import srd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // compressed byte stream
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // [7:0] data_byte
  // result stream
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [TdataW-1:0] m_axis_tdata_o,   // [19:0] pixel_offset, [51:20] pixel_value
  output logic [1:0]        m_axis_tuser_o,   // [1:0] kind
  // configuration writes
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [SizeW-1:0]  cfg_wdata_i
);

  typedef enum logic [1:0] {
    ST_CODE    = 2'b01,
    ST_LITERAL = 2'b10
  } state_e;

  logic [SizeW-1:0]   frame_width_q, frame_height_q;
  logic               half_alpha_q;
  state_e             state_q, state_d;
  logic [RunW-1:0]    left_q, left_d;
  logic [ColumnW-1:0] column_q, column_d;
  logic [OffsetW-1:0] row_base_q, row_base_d;
  logic [SizeW-1:0]   rows_done_q, rows_done_d;

  logic               in_accept;
  logic               res_valid;
  result_t            res;
  result_t            out_data;

  logic [SizeW-1:0]   eff_width, eff_height;
  logic [2*SizeW-1:0] area;
  logic [OffsetW:0]   off_sum;
  logic [ColumnW:0]   skip_sum;
  logic [OffsetW:0]   base_sum;
  logic [SizeW-1:0]   rows_inc;
  logic [7:0]         alpha;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= SizeW'(1);
      frame_height_q <= SizeW'(1);
      half_alpha_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        CFG_HALF_ALPHA:   half_alpha_q   <= cfg_wdata_i[0];
        default:          ;
      endcase
    end
  end

  // clamped frame size and area
  assign eff_width  = (frame_width_q > SizeW'(MaxWidth)) ? SizeW'(MaxWidth) : frame_width_q;
  assign eff_height = (frame_height_q > SizeW'(MaxHeight)) ? SizeW'(MaxHeight) : frame_height_q;
  assign area       = eff_width * eff_height;

  // address and counter arithmetic
  assign off_sum  = {1'b0, row_base_q} + (OffsetW+1)'(column_q);
  assign skip_sum = {1'b0, column_q} + (ColumnW+1)'(s_axis_tdata_i[RunW-1:0]);
  assign base_sum = {1'b0, row_base_q} + (OffsetW+1)'(eff_width);
  assign rows_inc = rows_done_q + SizeW'(1);
  assign alpha    = half_alpha_q ? AlphaHalf : AlphaFull;

  // decode one byte
  always_comb begin
    state_d     = state_q;
    left_d      = left_q;
    column_d    = column_q;
    row_base_d  = row_base_q;
    rows_done_d = rows_done_q;
    res_valid   = 1'b0;
    res.kind    = KIND_PIXEL;
    res.offset  = '0;
    res.value   = '0;
    if (in_accept) begin
      unique case (state_q)
        ST_LITERAL: begin
          res_valid  = 1'b1;
          res.kind   = ({1'b0, off_sum} >= area) ? KIND_DROPPED : KIND_PIXEL;
          res.offset = off_sum[OffsetW] ? OffsetLimit : off_sum[OffsetW-1:0];
          res.value  = {alpha, 16'h0000, s_axis_tdata_i};
          if (column_q != ColumnLimit) begin
            column_d = column_q + ColumnW'(1);
          end
          if (left_q != '0) begin
            left_d = left_q - RunW'(1);
          end
          if (left_q <= RunW'(1)) begin
            state_d = ST_CODE;
          end
        end
        ST_CODE: begin
          priority if (s_axis_tdata_i < RowEndCode) begin
            // skip pixels, column saturates
            column_d = skip_sum[ColumnW] ? ColumnLimit : skip_sum[ColumnW-1:0];
          end else if (s_axis_tdata_i > RowEndCode) begin
            // literal run header
            left_d  = s_axis_tdata_i[RunW-1:0];
            state_d = ST_LITERAL;
          end else begin
            // row end
            row_base_d  = base_sum[OffsetW] ? OffsetLimit : base_sum[OffsetW-1:0];
            column_d    = '0;
            rows_done_d = rows_inc;
            if (rows_inc >= eff_height) begin
              row_base_d  = '0;
              rows_done_d = '0;
              res_valid   = 1'b1;
              res.kind    = KIND_FRAME_END;
            end
          end
        end
        default: state_d = ST_CODE;
      endcase
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CODE;
      left_q      <= '0;
      column_q    <= '0;
      row_base_q  <= '0;
      rows_done_q <= '0;
    end else begin
      state_q     <= state_d;
      left_q      <= left_d;
      column_q    <= column_d;
      row_base_q  <= row_base_d;
      rows_done_q <= rows_done_d;
    end
  end

  // result register and skid entry
  srd_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (out_data),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {(TdataW-OffsetW-ValueW)'(0), out_data.value, out_data.offset};
  assign m_axis_tuser_o = out_data.kind;

  // a literal run always has bytes left
  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LITERAL |-> left_q != '0)
    else $error("literal run with no bytes left");

  // input stalls only while the output holds a result
  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty output");

  // every literal byte yields a result beat
  a_literal_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && state_q == ST_LITERAL |=> m_axis_tvalid_o)
    else $error("literal byte gave no result");

  // a frame end rearms the row counters
  a_frame_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.kind == KIND_FRAME_END |=> rows_done_q == '0 && row_base_q == '0)
    else $error("frame end did not rearm the counters");

endmodule
